// ===== design/rsi_pkg.sv =====
package rsi_pkg;

  localparam int FIX_W     = 32;
  localparam int ACC_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int QUO_BITS  = FIX_W - 1;
  localparam int RAD_W     = 31;
  localparam int MAT_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = QUO_BITS + 2;

  typedef logic signed [FIX_W-1:0] fix_t;

  localparam fix_t FIX_MAX = 32'sh7fffffff;
  localparam fix_t FIX_MIN = 32'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_RADIUS   = 3'd3,
    CFG_MATERIAL = 3'd4
  } cfg_reg_t;

  // Ray as it travels down the pipeline.
  typedef struct packed {
    fix_t [2:0] o;
    fix_t [2:0] d;
    fix_t       tl;
    fix_t       tu;
  } ray_t;

  typedef struct packed {
    ray_t ray;
    fix_t a;
    fix_t h;
    logic ok;
  } sq_side_t;

  typedef struct packed {
    ray_t ray;
    logic ok;
  } dv_side_t;

  typedef struct packed {
    logic       hit;
    fix_t       t;
    fix_t [2:0] p;
  } nm_side_t;

  // Clamp a wide signed value into the 32 bit fixed point range.
  function automatic fix_t sat32(input logic signed [67:0] v);
    if (v > 68'(FIX_MAX)) begin
      return FIX_MAX;
    end else if (v < 68'(FIX_MIN)) begin
      return FIX_MIN;
    end
    return fix_t'(v);
  endfunction

endpackage

// ===== design/rsi_isqrt.sv =====
module rsi_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rsi_pkg::ACC_W-1:0]    radicand,
  output logic [rsi_pkg::ROOT_W-1:0]   root
);
  import rsi_pkg::*;

  typedef struct packed {
    logic [ACC_W-1:0]  rem;
    logic [ROOT_W-1:0] res;
  } sq_stage_t;

  // One result bit: try setting bit b of the root against the running remainder.
  function automatic sq_stage_t sq_step(input logic [ACC_W-1:0] rem,
                                        input logic [ROOT_W-1:0] res, input int b);
    logic [ACC_W:0] trial;
    sq_stage_t      r;
    trial = ((ACC_W+1)'(res) << (b + 1)) + ((ACC_W+1)'(1) << (2 * b));
    if ((ACC_W+1)'(rem) >= trial) begin
      r.rem = rem - trial[ACC_W-1:0];
      r.res = res | (ROOT_W'(1) << b);
    end else begin
      r.rem = rem;
      r.res = res;
    end
    return r;
  endfunction

  sq_stage_t stg [ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= sq_step(radicand, '0, ROOT_W - 1);
      for (int j = 1; j < ROOT_W; j++) begin
        stg[j] <= sq_step(stg[j-1].rem, stg[j-1].res, ROOT_W - 1 - j);
      end
    end
  end

  assign root = stg[ROOT_W-1].res;

endmodule

// ===== design/rsi_div.sv =====
module rsi_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rsi_pkg::ACC_W-1:0]     num_mag,
  input  logic                          neg,
  input  logic [rsi_pkg::QUO_BITS-1:0]  den,
  output rsi_pkg::fix_t                 quo
);
  import rsi_pkg::*;

  logic [ACC_W-1:0]    rem [QUO_BITS+1];
  logic [QUO_BITS-1:0] qb  [QUO_BITS+1];
  logic [QUO_BITS-1:0] dv  [QUO_BITS+1];
  logic [QUO_BITS:0]   ng;
  logic [QUO_BITS:0]   ov;

  // First stage flags a quotient of 2^31 or more; then one quotient bit per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_mag;
      qb[0]  <= '0;
      dv[0]  <= den;
      ng[0]  <= neg;
      ov[0]  <= num_mag >= (ACC_W'(den) << QUO_BITS);
      for (int j = 0; j < QUO_BITS; j++) begin
        if (rem[j] >= (ACC_W'(dv[j]) << (QUO_BITS - 1 - j))) begin
          rem[j+1] <= rem[j] - (ACC_W'(dv[j]) << (QUO_BITS - 1 - j));
          qb[j+1]  <= qb[j] | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
        end else begin
          rem[j+1] <= rem[j];
          qb[j+1]  <= qb[j];
        end
        dv[j+1] <= dv[j];
        ng[j+1] <= ng[j];
        ov[j+1] <= ov[j];
      end
      if (ov[QUO_BITS]) begin
        quo <= ng[QUO_BITS] ? FIX_MIN : FIX_MAX;
      end else begin
        quo <= ng[QUO_BITS] ? -fix_t'({1'b0, qb[QUO_BITS]}) : fix_t'({1'b0, qb[QUO_BITS]});
      end
    end
  end

endmodule

// ===== design/ray_sphere_intersect_unit.sv =====
// Ray against sphere intersection test in signed fixed point (FRAC_BITS fraction bits).
// The sphere (center, radius, material) is set through the write port: cfg_write,
// cfg_index and cfg_data, one register per beat, while no ray is in flight.
// Each input beat on in_valid / in_stall carries one ray: origin, direction and the
// open interval (t_lower, t_upper). Each ray yields exactly one output beat on
// out_valid / out_stall with the hit flag, t, hit point, outward normal and material.
// A miss returns all result fields as zero.
// The datapath is one pipeline with a valid bit per stage. A new ray is taken every
// cycle while in_stall is low. The depth is set by the bit-serial square root
// (32 stages) and the two rows of divide stages (33 each), one for the roots and
// one for the normals.
// When the receiver holds out_stall while a result is shown, the whole pipeline
// freezes and in_stall is raised in the same cycle, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the sphere registers with
// center 0, radius 1.0 and material 0.
module ray_sphere_intersect_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rsi_pkg::fix_t                    origin_x,
  input  rsi_pkg::fix_t                    origin_y,
  input  rsi_pkg::fix_t                    origin_z,
  input  rsi_pkg::fix_t                    dir_x,
  input  rsi_pkg::fix_t                    dir_y,
  input  rsi_pkg::fix_t                    dir_z,
  input  rsi_pkg::fix_t                    t_lower,
  input  rsi_pkg::fix_t                    t_upper,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output rsi_pkg::fix_t                    hit_t,
  output rsi_pkg::fix_t                    point_x,
  output rsi_pkg::fix_t                    point_y,
  output rsi_pkg::fix_t                    point_z,
  output rsi_pkg::fix_t                    normal_x,
  output rsi_pkg::fix_t                    normal_y,
  output rsi_pkg::fix_t                    normal_z,
  output logic [rsi_pkg::MAT_W-1:0]        hit_material,
  input  logic                             cfg_write,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsi_pkg::FIX_W-1:0]        cfg_data
);
  import rsi_pkg::*;

  // Five front stages, square root, numerator stage, divider, four point stages,
  // normal divider and the output register.
  localparam int L = 5 + SQRT_LAT + 1 + DIV_LAT + 4 + DIV_LAT + 1;

  logic         en;
  logic [L-1:0] vld;

  // Sphere registers.
  fix_t             center_x, center_y, center_z;
  logic [RAD_W-1:0] sphere_radius;
  logic [MAT_W-1:0] material_id;
  logic [2*RAD_W-1:0] rr_prod;
  logic [2*RAD_W-1:0] rr;
  logic [RAD_W-1:0]   rden;
  fix_t ctr  [3];
  fix_t in_o [3];
  fix_t in_d [3];

  // Pipeline registers; pN_ is stage N.
  ray_t p1_ray;
  fix_t p1_oc [3];
  ray_t p2_ray;
  logic signed [ACC_W-1:0] p2_dd [3];
  logic signed [ACC_W-1:0] p2_od [3];
  logic signed [ACC_W-1:0] p2_oo [3];
  ray_t p3_ray;
  fix_t p3_a, p3_h, p3_c;
  ray_t p4_ray;
  fix_t p4_a, p4_h;
  logic signed [ACC_W-1:0] p4_hh, p4_ac;
  logic signed [ACC_W:0]   disc;
  sq_side_t p5_side;
  logic [ACC_W-1:0] p5_rad;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t sq_line [SQRT_LAT];
  sq_side_t sf;
  logic signed [33:0] h34, s34, n0, n1;
  logic [33:0] m0, m1;
  dv_side_t p6_side;
  logic [ACC_W-1:0] p6_num0, p6_num1;
  logic p6_neg0, p6_neg1;
  logic [QUO_BITS-1:0] p6_den;
  fix_t t0, t1;
  dv_side_t dv_line [DIV_LAT];
  dv_side_t dg;
  logic in0, in1;
  logic p7_hit;
  fix_t p7_t;
  ray_t p7_ray;
  logic p8_hit;
  fix_t p8_t;
  fix_t p8_o [3];
  logic signed [ACC_W-1:0] p8_td [3];
  logic p9_hit;
  fix_t p9_t;
  fix_t p9_p [3];
  logic signed [FIX_W:0] diff [3];
  logic [FIX_W:0] dmag [3];
  nm_side_t p10_side;
  logic [ACC_W-1:0] p10_num [3];
  logic p10_neg [3];
  fix_t nq [3];
  nm_side_t nm_line [DIV_LAT];
  nm_side_t ns;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // Configuration writes; indexes past the material register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= RAD_W'(1 << FRAC_BITS);
      material_id   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CENTER_X: center_x <= fix_t'(cfg_data);
        CFG_CENTER_Y: center_y <= fix_t'(cfg_data);
        CFG_CENTER_Z: center_z <= fix_t'(cfg_data);
        CFG_RADIUS:   sphere_radius <= cfg_data[RAD_W-1:0];
        CFG_MATERIAL: material_id <= cfg_data[MAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Values that depend only on the radius are kept ready in registers. A zero
  // radius divides the normal by one LSB instead.
  assign rr_prod = sphere_radius * sphere_radius;

  always_ff @(posedge clk) begin
    rr   <= rr_prod >> FRAC_BITS;
    rden <= (sphere_radius == '0) ? RAD_W'(1) : sphere_radius;
  end

  assign ctr[0]  = center_x;
  assign ctr[1]  = center_y;
  assign ctr[2]  = center_z;
  assign in_o[0] = origin_x;
  assign in_o[1] = origin_y;
  assign in_o[2] = origin_z;
  assign in_d[0] = dir_x;
  assign in_d[1] = dir_y;
  assign in_d[2] = dir_z;

  // Stage 1: capture the ray and form O - C, saturated per component.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_ray.o[i] <= in_o[i];
        p1_ray.d[i] <= in_d[i];
        p1_oc[i]    <= sat32(68'(in_o[i]) - 68'(ctr[i]));
      end
      p1_ray.tl <= t_lower;
      p1_ray.tu <= t_upper;
    end
  end

  // Stage 2: the nine dot product terms, each floored to FRAC_BITS fraction bits.
  always_ff @(posedge clk) begin
    if (en) begin
      p2_ray <= p1_ray;
      for (int i = 0; i < 3; i++) begin
        p2_dd[i] <= ($signed(p1_ray.d[i]) * $signed(p1_ray.d[i])) >>> FRAC_BITS;
        p2_od[i] <= (p1_oc[i] * $signed(p1_ray.d[i])) >>> FRAC_BITS;
        p2_oo[i] <= (p1_oc[i] * p1_oc[i]) >>> FRAC_BITS;
      end
    end
  end

  // Stage 3: a = D.D, h = (O-C).D and c = (O-C).(O-C) - R^2, each saturated.
  always_ff @(posedge clk) begin
    if (en) begin
      p3_ray <= p2_ray;
      p3_a   <= sat32(68'(p2_dd[0]) + 68'(p2_dd[1]) + 68'(p2_dd[2]));
      p3_h   <= sat32(68'(p2_od[0]) + 68'(p2_od[1]) + 68'(p2_od[2]));
      p3_c   <= sat32(68'(p2_oo[0]) + 68'(p2_oo[1]) + 68'(p2_oo[2])
                      - $signed({6'b0, rr}));
    end
  end

  // Stage 4: the two products of the half-b discriminant.
  always_ff @(posedge clk) begin
    if (en) begin
      p4_ray <= p3_ray;
      p4_a   <= p3_a;
      p4_h   <= p3_h;
      p4_hh  <= p3_h * p3_h;
      p4_ac  <= p3_a * p3_c;
    end
  end

  // Stage 5: disc = h*h - a*c. A flat ray or a non-positive discriminant is a miss.
  assign disc = (ACC_W+1)'(p4_hh) - (ACC_W+1)'(p4_ac);

  always_ff @(posedge clk) begin
    if (en) begin
      p5_side.ray <= p4_ray;
      p5_side.a   <= p4_a;
      p5_side.h   <= p4_h;
      p5_side.ok  <= (p4_a > 0) && (disc > 0);
      p5_rad      <= (disc > 0) ? disc[ACC_W-1:0] : '0;
    end
  end

  rsi_isqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (p5_rad),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_line[0] <= p5_side;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sq_line[k] <= sq_line[k-1];
      end
    end
  end

  // Stage 6: numerators -h - s and -h + s, scaled up by FRAC_BITS for the divide.
  assign sf  = sq_line[SQRT_LAT-1];
  assign h34 = 34'(sf.h);
  assign s34 = $signed({2'b0, sq_root});
  assign n0  = -h34 - s34;
  assign n1  = s34 - h34;
  assign m0  = n0[33] ? 34'(-n0) : 34'(n0);
  assign m1  = n1[33] ? 34'(-n1) : 34'(n1);

  always_ff @(posedge clk) begin
    if (en) begin
      p6_side.ray <= sf.ray;
      p6_side.ok  <= sf.ok;
      p6_num0     <= ACC_W'(m0) << FRAC_BITS;
      p6_num1     <= ACC_W'(m1) << FRAC_BITS;
      p6_neg0     <= n0[33];
      p6_neg1     <= n1[33];
      p6_den      <= sf.a[QUO_BITS-1:0];
    end
  end

  rsi_div u_div_near (
    .clk     (clk),
    .en      (en),
    .num_mag (p6_num0),
    .neg     (p6_neg0),
    .den     (p6_den),
    .quo     (t0)
  );

  rsi_div u_div_far (
    .clk     (clk),
    .en      (en),
    .num_mag (p6_num1),
    .neg     (p6_neg1),
    .den     (p6_den),
    .quo     (t1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_line[0] <= p6_side;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_line[k] <= dv_line[k-1];
      end
    end
  end

  // Stage 7: the nearer root wins when it lies strictly inside the interval.
  // A saturated root sits at a range extreme and so can never pass the test.
  assign dg  = dv_line[DIV_LAT-1];
  assign in0 = dg.ok && (t0 > dg.ray.tl) && (t0 < dg.ray.tu);
  assign in1 = dg.ok && (t1 > dg.ray.tl) && (t1 < dg.ray.tu);

  always_ff @(posedge clk) begin
    if (en) begin
      p7_hit <= in0 || in1;
      p7_t   <= in0 ? t0 : t1;
      p7_ray <= dg.ray;
    end
  end

  // Stage 8: t * D per component.
  always_ff @(posedge clk) begin
    if (en) begin
      p8_hit <= p7_hit;
      p8_t   <= p7_t;
      for (int i = 0; i < 3; i++) begin
        p8_o[i]  <= p7_ray.o[i];
        p8_td[i] <= p7_t * $signed(p7_ray.d[i]);
      end
    end
  end

  // Stage 9: hit point O + floor(t*D), saturated.
  always_ff @(posedge clk) begin
    if (en) begin
      p9_hit <= p8_hit;
      p9_t   <= p8_t;
      for (int i = 0; i < 3; i++) begin
        p9_p[i] <= sat32(68'(p8_o[i]) + 68'(p8_td[i] >>> FRAC_BITS));
      end
    end
  end

  // Stage 10: P - C as sign and scaled magnitude for the normal dividers.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (FIX_W+1)'(p9_p[i]) - (FIX_W+1)'(ctr[i]);
      dmag[i] = diff[i][FIX_W] ? (FIX_W+1)'(-diff[i]) : (FIX_W+1)'(diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p10_side.hit <= p9_hit;
      p10_side.t   <= p9_t;
      for (int i = 0; i < 3; i++) begin
        p10_side.p[i] <= p9_p[i];
        p10_num[i]    <= ACC_W'(dmag[i]) << FRAC_BITS;
        p10_neg[i]    <= diff[i][FIX_W];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_norm
    rsi_div u_div_norm (
      .clk     (clk),
      .en      (en),
      .num_mag (p10_num[i]),
      .neg     (p10_neg[i]),
      .den     (rden),
      .quo     (nq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_line[0] <= p10_side;
      for (int k = 1; k < DIV_LAT; k++) begin
        nm_line[k] <= nm_line[k-1];
      end
    end
  end

  // Output register; a miss shows all fields as zero.
  assign ns = nm_line[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      hit          <= ns.hit;
      hit_t        <= ns.hit ? ns.t : '0;
      point_x      <= ns.hit ? fix_t'(ns.p[0]) : '0;
      point_y      <= ns.hit ? fix_t'(ns.p[1]) : '0;
      point_z      <= ns.hit ? fix_t'(ns.p[2]) : '0;
      normal_x     <= ns.hit ? nq[0] : '0;
      normal_y     <= ns.hit ? nq[1] : '0;
      normal_z     <= ns.hit ? nq[2] : '0;
      hit_material <= ns.hit ? material_id : '0;
    end
  end

  // A stalled result freezes every stage of the pipeline.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(out_valid && out_stall) |-> $stable(vld))
    else $error("pipeline moved while the result beat was stalled");

  // A miss carries zero in hit_t, point_x, normal_x and hit_material.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_t == '0 && point_x == '0 && normal_x == '0
                          && hit_material == '0)
    else $error("miss beat with nonzero result fields");

  // A saturated root must never be reported as a hit.
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> hit_t != FIX_MAX && hit_t != FIX_MIN)
    else $error("hit reported at a saturated ray parameter");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rsi_pkg::*;

  localparam int FRAC      = 16;
  localparam longint ONE   = 64'sd65536;
  localparam int WDOG_MAX  = 4000;
  localparam int HOLD_LEN  = 300;
  localparam int DRAIN_GAP = 150;
  localparam int RAND_PER  = 185;

  // One intersection answer: f[0] is t, f[1..3] the point, f[4..6] the normal.
  typedef struct packed {
    logic           hit;
    fix_t [6:0]     f;
    logic [MAT_W-1:0] mat;
  } isect_t;

  typedef struct packed {
    ray_t   ray;
    logic   typed;
    isect_t want;
  } ray_vec_t;

  logic clk;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_stall;
  fix_t origin_x = '0, origin_y = '0, origin_z = '0;
  fix_t dir_x = '0, dir_y = '0, dir_z = '0;
  fix_t t_lower = '0, t_upper = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  fix_t hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z;
  logic [MAT_W-1:0] hit_material;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIX_W-1:0] cfg_data = '0;

  ray_sphere_intersect_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .t_lower(t_lower), .t_upper(t_upper),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .hit_t(hit_t),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .hit_material(hit_material),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Our copy of the sphere registers, updated as each write goes out.
  longint     sph_ctr[3];
  longint     sph_rad;
  logic [7:0] sph_mat;

  isect_t pending_hits[$];
  int     err_cnt = 0;
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  bit     hold_req = 0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Solve the half-b quadratic against the current sphere and pick the first
  // root strictly inside (t_lower, t_upper). A miss leaves everything zero.
  function automatic isect_t trace_sphere(ray_t r);
    longint o[3], d[3], oc[3];
    longint a, h, c, s, num, t, p, n, rden;
    logic signed [79:0] disc;
    isect_t e;
    e = '0;
    a = 0;
    h = 0;
    c = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(r.o[i]);
      d[i] = longint'(r.d[i]);
      oc[i] = clamp32(o[i] - sph_ctr[i]);
    end
    for (int i = 0; i < 3; i++) begin
      a += (d[i] * d[i]) >>> FRAC;
      h += (oc[i] * d[i]) >>> FRAC;
      c += (oc[i] * oc[i]) >>> FRAC;
    end
    c -= (sph_rad * sph_rad) >>> FRAC;
    a = clamp32(a);
    h = clamp32(h);
    c = clamp32(c);
    disc = 80'(h) * 80'(h) - 80'(a) * 80'(c);
    if (a <= 0 || disc <= 0) begin
      return e;
    end
    s = longint'(floor_sqrt(disc[63:0]));
    rden = (sph_rad == 0) ? 1 : sph_rad;
    for (int k = 0; k < 2; k++) begin
      num = (k == 0) ? -h - s : -h + s;
      t = clamp32((num * ONE) / a);
      if (t > longint'(r.tl) && t < longint'(r.tu)) begin
        e.hit = 1'b1;
        e.f[0] = fix_t'(t);
        for (int i = 0; i < 3; i++) begin
          p = clamp32(o[i] + ((t * d[i]) >>> FRAC));
          n = clamp32(((p - sph_ctr[i]) * ONE) / rden);
          e.f[1+i] = fix_t'(p);
          e.f[4+i] = fix_t'(n);
        end
        e.mat = sph_mat;
        return e;
      end
    end
    return e;
  endfunction

  function automatic ray_t mk_ray(fix_t ox, fix_t oy, fix_t oz, fix_t dx, fix_t dy,
                                  fix_t dz, fix_t lo, fix_t hi);
    ray_t r;
    r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
    r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
    r.tl = lo;
    r.tu = hi;
    return r;
  endfunction

  // The receiver: checks each accepted beat, then decides the next stall.
  always @(posedge clk) begin
    isect_t got, want;
    string  fname[7];
    fname = '{"hit_t", "point_x", "point_y", "point_z", "normal_x", "normal_y", "normal_z"};
    if (!rst && out_valid && !out_stall) begin
      got.hit = hit;
      got.f[0] = hit_t;
      got.f[1] = point_x; got.f[2] = point_y; got.f[3] = point_z;
      got.f[4] = normal_x; got.f[5] = normal_y; got.f[6] = normal_z;
      got.mat = hit_material;
      if (pending_hits.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, hit=%0b t=%h", $time,
                 got.hit, got.f[0]);
        err_cnt++;
      end else begin
        want = pending_hits.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
          err_cnt++;
        end
        for (int i = 0; i < 7; i++) begin
          if (got.f[i] !== want.f[i]) begin
            $display("%0t: %s expected %h actual %h", $time, fname[i], want.f[i], got.f[i]);
            err_cnt++;
          end
        end
        if (got.mat !== want.mat) begin
          $display("%0t: hit_material expected %h actual %h", $time, want.mat, got.mat);
          err_cnt++;
        end
      end
    end
    // A long hold is asked for by the stimulus thread but counted down here.
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog: any cycle in which neither channel moves a beat counts toward the limit.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // The caller drops cfg_write once its last write has gone out.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIX_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_CENTER_X: sph_ctr[0] = longint'($signed(val));
      CFG_CENTER_Y: sph_ctr[1] = longint'($signed(val));
      CFG_CENTER_Z: sph_ctr[2] = longint'($signed(val));
      CFG_RADIUS:   sph_rad = longint'({1'b0, val[RAD_W-1:0]});
      CFG_MATERIAL: sph_mat = val[MAT_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one ray until it is taken, queue its answer, then maybe idle a while.
  task automatic send_ray(ray_t r, logic typed, isect_t want);
    in_valid <= 1'b1;
    origin_x <= r.o[0]; origin_y <= r.o[1]; origin_z <= r.o[2];
    dir_x <= r.d[0]; dir_y <= r.d[1]; dir_z <= r.d[2];
    t_lower <= r.tl;
    t_upper <= r.tu;
    do @(posedge clk); while (in_stall);
    pending_hits.push_back(typed ? want : trace_sphere(r));
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Random ray: mostly placed near the sphere and often aimed at it, the rest raw noise.
  function automatic ray_t rand_ray();
    ray_t r;
    longint off, lo, hi;
    if ($urandom_range(99) < 25) begin
      return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
    end
    for (int i = 0; i < 3; i++) begin
      off = longint'($signed($urandom)) >>> $urandom_range(10, 22);
      r.o[i] = fix_t'(clamp32(sph_ctr[i] + off));
      if ($urandom_range(1)) begin
        r.d[i] = fix_t'(clamp32((sph_ctr[i] - longint'(r.o[i])) >>> $urandom_range(0, 6)
                                + (longint'($signed($urandom)) >>> 26)));
      end else begin
        r.d[i] = fix_t'($signed($urandom) >>> $urandom_range(12, 20));
      end
    end
    lo = $urandom_range(3) == 0 ? -longint'($urandom_range(0, 1 << 20)) : 0;
    hi = $urandom_range(3) == 0 ? 64'sd2147483647 : longint'($urandom_range(0, 1 << 30));
    if ($urandom_range(19) == 0) begin
      r.tl = fix_t'(hi);
      r.tu = fix_t'(lo);
    end else begin
      r.tl = fix_t'(lo);
      r.tu = fix_t'(hi);
    end
    return r;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  initial begin
    ray_vec_t   vecs[$];
    isect_t     miss, first_hit;
    fix_t       sets[6][5];
    ray_vec_t   v;

    sph_ctr = '{0, 0, 0};
    sph_rad = ONE;
    sph_mat = 8'd0;
    miss = '0;

    // Unit sphere at the origin, ray from z = -2 along +z: enters at t = 1.0.
    first_hit = '0;
    first_hit.hit = 1'b1;
    first_hit.f[0] = 32'sd65536;
    first_hit.f[3] = -32'sd65536;
    first_hit.f[6] = -32'sd65536;

    // Directed rays against the reset sphere. Typed answers where they are plain.
    vecs.push_back('{mk_ray(0, 0, -131072, 0, 0, 65536, 0, 655360), 1'b1, first_hit});
    // Origin inside the sphere: the near root is behind, the far one counts.
    vecs.push_back('{mk_ray(0, 0, 0, 0, 0, 65536, 0, 655360), 1'b0, miss});
    // Zero direction and a direction too short for a to survive flooring.
    vecs.push_back('{mk_ray(0, 0, -131072, 0, 0, 0, 0, 655360), 1'b1, miss});
    vecs.push_back('{mk_ray(0, 0, -131072, 1, 0, 0, 0, 655360), 1'b1, miss});
    // Empty interval, reversed and degenerate.
    vecs.push_back('{mk_ray(0, 0, -131072, 0, 0, 65536, 327680, 65536), 1'b1, miss});
    vecs.push_back('{mk_ray(0, 0, -131072, 0, 0, 65536, 65536, 65536), 1'b1, miss});
    // Tangent ray: discriminant exactly zero.
    vecs.push_back('{mk_ray(0, 65536, -131072, 0, 0, 65536, 0, 655360), 1'b1, miss});
    // Pointing away: both roots negative.
    vecs.push_back('{mk_ray(0, 0, -131072, 0, 0, -65536, 0, 655360), 1'b1, miss});
    // Interval ends before the near root.
    vecs.push_back('{mk_ray(0, 0, -131072, 0, 0, 65536, 0, 32768), 1'b1, miss});
    // Lower bound sits on the near root, so only the far root qualifies.
    vecs.push_back('{mk_ray(0, 0, -131072, 0, 0, 65536, 65536, 655360), 1'b0, miss});
    // Widest interval.
    vecs.push_back('{mk_ray(0, 0, -131072, 0, 0, 65536, FIX_MIN, FIX_MAX), 1'b0, miss});
    // Field extremes and bit patterns.
    vecs.push_back('{mk_ray(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
                            FIX_MAX), 1'b0, miss});
    vecs.push_back('{mk_ray(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                            FIX_MIN), 1'b0, miss});
    vecs.push_back('{mk_ray(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                            32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555),
                     1'b0, miss});
    vecs.push_back('{mk_ray(FIX_MIN, 0, 0, FIX_MAX, 0, 0, FIX_MIN, FIX_MAX), 1'b0, miss});
    // Tiny step from far away: the far root saturates and must be rejected.
    vecs.push_back('{mk_ray(0, 0, FIX_MIN, 0, 0, 256, FIX_MIN, FIX_MAX), 1'b0, miss});
    vecs.push_back('{mk_ray(-32768, 16384, -196608, 32768, -8192, 98304, -65536, FIX_MAX),
                     1'b0, miss});

    // Sphere settings per phase: center x, y, z, radius, material.
    sets[0] = '{0, 0, 0, 65536, 0};
    sets[1] = '{196608, -131072, 327680, 131072, 17};
    sets[2] = '{FIX_MAX, FIX_MIN, 0, 32'hffffffff, 255};
    sets[3] = '{FIX_MIN, FIX_MAX, -1, 1, 0};
    sets[4] = '{0, 0, 0, 0, 128};
    sets[5] = '{-491520, 16384, 6553600, 32768, 8'ha5};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      // Sender dense and receiver busy, then the reverse, then both flat out.
      tx_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 69 : 0;
      rx_stall_pct = (ph < 2) ? 69 : (ph < 4) ? 10 : 0;
      wait_drained();
      if (ph > 0) begin
        write_reg(CFG_CENTER_X, sets[ph][0]);
        write_reg(CFG_CENTER_Y, sets[ph][1]);
        write_reg(CFG_CENTER_Z, sets[ph][2]);
        write_reg(CFG_RADIUS, sets[ph][3]);
        write_reg(CFG_MATERIAL, sets[ph][4]);
        // Writes past the last register must leave the sphere alone.
        write_reg(CFG_IDX_W'(5 + ph % 3), $urandom);
        cfg_write <= 1'b0;
      end else begin
        foreach (vecs[i]) begin
          v = vecs[i];
          send_ray(v.ray, v.typed, v.want);
        end
      end
      for (int n = 0; n < RAND_PER; n++) begin
        if (ph == 0 && n == 60) begin
          hold_req = 1;
        end
        if (ph == 1 && n == 80) begin
          wait_drained();
        end
        send_ray(rand_ray(), 1'b0, miss);
      end
    end

    wait_drained();
    repeat (DRAIN_GAP) @(posedge clk);
    if (err_cnt == 0 && pending_hits.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rsi_pkg.sv
design/rsi_isqrt.sv
design/rsi_div.sv
design/ray_sphere_intersect_unit.sv
sim/tb_top.sv
